FILE: hw/rtl/tcspq_pkg.sv
package tcspq_pkg;

   // Field widths of the channels and the capacity register
   localparam int CLASS_W    = 2;
   localparam int ID_FIELD_W = 16;
   localparam int STATUS_W   = 3;
   localparam int CAP_W      = 5;

   localparam int CLASS_COUNT = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request codes
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   localparam logic [CLASS_W-1:0] CLASS_INVALID = 2'd3;
   localparam logic [CLASS_W-1:0] CLASS_NONE    = 2'd0;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_PUSHED   = 3'd0,
      STATUS_OVERFLOW = 3'd1,
      STATUS_INVALID  = 3'd2,
      STATUS_POPPED   = 3'd3,
      STATUS_EMPTY    = 3'd4
   } status_type;

   typedef struct packed {
      logic                  mode;
      logic [CLASS_W-1:0]    item_class;
      logic [ID_FIELD_W-1:0] item_id;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [CLASS_W-1:0]    served_class;
      logic [ID_FIELD_W-1:0] served_id;
   } rsp_type;

endpackage

FILE: hw/rtl/tcspq_id_store.sv
// Identifier store: one write port, one read port, registered read data
module tcspq_id_store
   import tcspq_pkg::*;
#(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 16,
   parameter int DEPTH  = 48
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data valid the cycle after rd_en
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: hw/rtl/three_class_strict_priority_queue.sv
// Channel   Direction  Transfer when          Payload
// req_      in         req_valid & !req_stall req_data (mode, item_class, item_id)
// rsp_      out        rsp_valid & !rsp_stall rsp_data (status, served_class, served_id)
// csr_      in         csr_write_enable       csr_write_data (queue_capacity)
//
// One request per cycle while req_stall is low; each request gives one response
// through the read stage (the store's registered read) and the output register.
// Pointers and fill counts update at the request transfer. Reset is synchronous:
// all queues empty, capacity 16. req_stall rises only while a response is held by
// rsp_stall and a second one sits in the read stage behind it.
module three_class_strict_priority_queue
   import tcspq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_write_enable,
   input  logic [CAP_W-1:0] csr_write_data
);

   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int KEEP_W      = (ID_WIDTH < ID_FIELD_W) ? ID_WIDTH : ID_FIELD_W;
   localparam int ADDR_W      = CLASS_W + IDX_W;
   localparam int STORE_DEPTH = CLASS_COUNT * (1 << IDX_W);
   localparam int TOTAL_W     = CNT_W + 2;

   logic [CAP_W-1:0]  capacity_ff;
   logic [CMP_W-1:0]  cap_eff;

   logic [IDX_W-1:0]  head_ff  [CLASS_COUNT];
   logic [IDX_W-1:0]  head_in  [CLASS_COUNT];
   logic [IDX_W-1:0]  tail_ff  [CLASS_COUNT];
   logic [IDX_W-1:0]  tail_in  [CLASS_COUNT];
   logic [CNT_W-1:0]  count_ff [CLASS_COUNT];
   logic [CNT_W-1:0]  count_in [CLASS_COUNT];

   // read stage
   logic              s1_valid_ff, s1_valid_in;
   status_type        s1_status_ff, s1_status_in;
   logic [CLASS_W-1:0] s1_class_ff, s1_class_in;
   logic              s1_take_id_ff, s1_take_id_in;

   // output stage
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_accept, s1_advance;
   logic              pop_found;
   logic [CLASS_W-1:0] pop_class;
   logic [CLASS_W-1:0] push_class;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [KEEP_W-1:0] rd_data;
   logic [TOTAL_W-1:0] fill_total;

   // handshake
   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign push_class = req_data.item_class;

   // capacity clamped to 1..QUEUE_DEPTH
   always_comb begin
      cap_eff = CMP_W'(capacity_ff);
      if (cap_eff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_eff > CMP_W'(QUEUE_DEPTH)) begin
         cap_eff = CMP_W'(QUEUE_DEPTH);
      end
   end

   // highest-priority nonempty class
   always_comb begin
      pop_found = 1'b0;
      pop_class = CLASS_NONE;
      for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
         if (count_ff[c] != '0) begin
            pop_found = 1'b1;
            pop_class = CLASS_W'(c);
         end
      end
   end

   // request decode, pointer update and store access
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      s1_status_in  = s1_status_ff;
      s1_class_in   = s1_class_ff;
      s1_take_id_in = s1_take_id_ff;
      s1_valid_in   = s1_valid_ff && !s1_advance;

      if (req_accept) begin
         s1_valid_in   = 1'b1;
         s1_class_in   = CLASS_NONE;
         s1_take_id_in = 1'b0;
         if (req_data.mode == MODE_PUSH) begin
            if (push_class == CLASS_INVALID) begin
               s1_status_in = STATUS_INVALID;
            end else if (CMP_W'(count_ff[push_class]) >= cap_eff) begin
               s1_status_in = STATUS_OVERFLOW;
            end else begin
               s1_status_in         = STATUS_PUSHED;
               s1_class_in          = push_class;
               wr_en                = 1'b1;
               wr_addr              = {push_class, tail_ff[push_class]};
               tail_in[push_class]  = (tail_ff[push_class] == IDX_W'(QUEUE_DEPTH - 1)) ?
                                      '0 : tail_ff[push_class] + 1'b1;
               count_in[push_class] = count_ff[push_class] + 1'b1;
            end
         end else if (pop_found) begin
            s1_status_in        = STATUS_POPPED;
            s1_class_in         = pop_class;
            s1_take_id_in       = 1'b1;
            rd_en               = 1'b1;
            rd_addr             = {pop_class, head_ff[pop_class]};
            head_in[pop_class]  = (head_ff[pop_class] == IDX_W'(QUEUE_DEPTH - 1)) ?
                                  '0 : head_ff[pop_class] + 1'b1;
            count_in[pop_class] = count_ff[pop_class] - 1'b1;
         end else begin
            s1_status_in = STATUS_EMPTY;
         end
      end
   end

   // response register loads from the read stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (s1_valid_ff && s1_advance) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.status       = s1_status_ff;
         rsp_data_in.served_class = s1_class_ff;
         rsp_data_in.served_id    = s1_take_id_ff ? ID_FIELD_W'(rd_data) : '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CLASS_COUNT; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_status_ff  <= s1_status_in;
      s1_class_ff   <= s1_class_in;
      s1_take_id_ff <= s1_take_id_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // a push and a pop never share a cycle, so the store needs no forwarding
   tcspq_id_store #(
      .ADDR_W (ADDR_W),
      .DATA_W (KEEP_W),
      .DEPTH  (STORE_DEPTH)
   ) u_id_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.item_id[KEEP_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      fill_total = '0;
      for (int c = 0; c < CLASS_COUNT; c++) begin
         fill_total = fill_total + TOTAL_W'(count_ff[c]);
      end
   end

   // fill never exceeds the queue depth
   for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_fill_check
      assert property (@(posedge clock) disable iff (reset)
         count_ff[g] <= CNT_W'(QUEUE_DEPTH))
         else $error("class fill above queue depth");
   end

   // total fill moves by at most one entry per cycle
   assert property (@(posedge clock) disable iff (reset)
      !reset |=> (fill_total == $past(fill_total)) ||
                 (fill_total == $past(fill_total) + 1'b1) ||
                 (fill_total + 1'b1 == $past(fill_total)))
      else $error("fill moved by more than one");

   // a pop with the top class nonempty takes from the top class
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.mode == MODE_POP && count_ff[0] != '0 |=>
         count_ff[0] == $past(count_ff[0]) - 1'b1)
      else $error("pop skipped the highest class");

   // the read stage always hands on to the output register
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> rsp_valid_ff)
      else $error("read stage result lost");

endmodule

FILE: tb/sv/priority_queue_checker.sv
module priority_queue_checker
   import tcspq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_write_enable,
   input  logic [CAP_W-1:0]      csr_write_data,
   output int                    mismatch_count,
   output int                    responses_outstanding,
   output int                    popped_count,
   output int                    overflow_count
);

   localparam logic [ID_FIELD_W-1:0] ID_KEEP = (ID_WIDTH >= ID_FIELD_W) ?
      {ID_FIELD_W{1'b1}} : ID_FIELD_W'((64'd1 << ID_WIDTH) - 64'd1);

   // Shadow copy of the three class FIFOs and the capacity register
   logic [ID_FIELD_W-1:0] shadow_ids [CLASS_COUNT][QUEUE_DEPTH];
   int                    shadow_head [CLASS_COUNT];
   int                    shadow_fill [CLASS_COUNT];
   logic [CAP_W-1:0]      capacity_setting;

   // Responses predicted for accepted requests, oldest first
   rsp_type awaited_responses [$];

   initial begin
      mismatch_count        = 0;
      responses_outstanding = 0;
      popped_count          = 0;
      overflow_count        = 0;
      capacity_setting      = CAP_RESET;
   end

   // Apply one request to the shadow state and return the response it earns
   function automatic rsp_type serve_request(req_type item);
      rsp_type outcome;
      int      limit;
      int      slot;
      logic    found;
      outcome.status       = STATUS_EMPTY;
      outcome.served_class = CLASS_NONE;
      outcome.served_id    = '0;
      found = 1'b0;
      // capacity saturates into 1..QUEUE_DEPTH
      if (capacity_setting == 0) begin
         limit = 1;
      end else if (int'(capacity_setting) > QUEUE_DEPTH) begin
         limit = QUEUE_DEPTH;
      end else begin
         limit = int'(capacity_setting);
      end
      if (item.mode == MODE_PUSH) begin
         if (item.item_class == CLASS_INVALID) begin
            outcome.status = STATUS_INVALID;
         end else if (shadow_fill[item.item_class] >= limit) begin
            outcome.status = STATUS_OVERFLOW;
         end else begin
            slot = (shadow_head[item.item_class] + shadow_fill[item.item_class]) % QUEUE_DEPTH;
            shadow_ids[item.item_class][slot] = item.item_id & ID_KEEP;
            shadow_fill[item.item_class]++;
            outcome.status       = STATUS_PUSHED;
            outcome.served_class = item.item_class;
         end
      end else begin
         // strict priority: lowest class number that holds anything
         for (int c = 0; c < CLASS_COUNT; c++) begin
            if (!found && shadow_fill[c] != 0) begin
               found = 1'b1;
               outcome.served_id    = shadow_ids[c][shadow_head[c]];
               shadow_head[c]       = (shadow_head[c] + 1) % QUEUE_DEPTH;
               shadow_fill[c]--;
               outcome.status       = STATUS_POPPED;
               outcome.served_class = CLASS_W'(c);
            end
         end
      end
      return outcome;
   endfunction

   // Track transfers on both channels and compare each response
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int c = 0; c < CLASS_COUNT; c++) begin
            shadow_head[c] = 0;
            shadow_fill[c] = 0;
         end
         capacity_setting = CAP_RESET;
         awaited_responses.delete();
         responses_outstanding <= 0;
      end else begin
         if (csr_write_enable) begin
            capacity_setting = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $error("response transfer with nothing outstanding: status %0d id %0h",
                      rsp_data.status, rsp_data.served_id);
               mismatch_count++;
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatch_count++;
               end
               if (rsp_data.served_class !== want.served_class) begin
                  $error("served_class: expected %0d, got %0d",
                         want.served_class, rsp_data.served_class);
                  mismatch_count++;
               end
               if (rsp_data.served_id !== want.served_id) begin
                  $error("served_id: expected %0h, got %0h", want.served_id, rsp_data.served_id);
                  mismatch_count++;
               end
               if (want.status == STATUS_POPPED) popped_count++;
               if (want.status == STATUS_OVERFLOW) overflow_count++;
            end
         end
         if (req_valid && !req_stall) begin
            awaited_responses.push_back(serve_request(req_data));
         end
         responses_outstanding <= awaited_responses.size();
      end
   end

endmodule

FILE: tb/sv/tb_three_class_strict_priority_queue.sv
module tb_three_class_strict_priority_queue;
   import tcspq_pkg::*;

   localparam int PHASES           = 9;
   localparam int ITEMS_PER_PHASE  = 66;
   localparam int LONG_HOLD_CYCLES = 80;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [CAP_W-1:0] csr_write_data = '0;

   int mismatch_count;
   int responses_outstanding;
   int popped_count;
   int overflow_count;

   // Pacing knobs shared by the request and response sides
   int unsigned req_gap_pct   = 0;
   int unsigned rsp_stall_pct = 0;
   logic        hold_request  = 1'b0;
   logic        hold_active   = 1'b0;
   int          requests_sent = 0;
   int          capacity_settings = 0;

   logic [CAP_W-1:0] phase_caps [8]    = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd2, 5'd9, 5'd17};
   int unsigned      phase_push [PHASES] = '{85, 60, 30, 90, 50, 70, 40, 80, 60};
   int unsigned      pacing_pct [3]    = '{10, 25, 50};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   three_class_strict_priority_queue DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   priority_queue_checker #(
      .QUEUE_DEPTH (16),
      .ID_WIDTH    (16)
   ) service_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_data              (req_data),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_data              (rsp_data),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .mismatch_count        (mismatch_count),
      .responses_outstanding (responses_outstanding),
      .popped_count          (popped_count),
      .overflow_count        (overflow_count)
   );

   // Mostly short gaps, now and then a long one
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) return $urandom_range(2, 1);
      if (pick < 92) return $urandom_range(6, 3);
      return $urandom_range(30, 10);
   endfunction

   function automatic req_type make_request(logic mode, logic [CLASS_W-1:0] cls,
                                            logic [ID_FIELD_W-1:0] id);
      req_type item;
      item.mode       = mode;
      item.item_class = cls;
      item.item_id    = id;
      return item;
   endfunction

   // Random request: push share set per phase, an invalid class now and then
   function automatic req_type random_request(int unsigned push_pct);
      req_type item;
      item.mode       = ($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP;
      item.item_class = ($urandom_range(19) == 0) ? CLASS_INVALID : CLASS_W'($urandom_range(2));
      item.item_id    = ID_FIELD_W'($urandom());
      return item;
   endfunction

   // Present one request, optionally after a gap, and hold it until its transfer
   task automatic offer_request(req_type item);
      int unsigned gap;
      if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         gap = idle_length();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   // Stop offering and let every outstanding response drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (responses_outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_capacity(logic [CAP_W-1:0] value);
      wait_idle();
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity_settings++;
   endtask

   // Response side: random stall bursts, plus one long hold-off on request
   initial begin : response_pacer
      int unsigned run;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active  = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_active = 1'b0;
         end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
            run = idle_length();
            rsp_stall <= 1'b1;
            repeat (run) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty pop, invalid class, then items in classes 2, 1 and 0 (two in class 0) drained in priority order
      offer_request(make_request(MODE_POP, CLASS_INVALID, 16'hFFFF));
      offer_request(make_request(MODE_PUSH, CLASS_INVALID, 16'hFFFF));
      offer_request(make_request(MODE_PUSH, 2'd2, 16'hFFFF));
      offer_request(make_request(MODE_PUSH, 2'd1, 16'h0000));
      offer_request(make_request(MODE_PUSH, 2'd0, 16'hA5A5));
      offer_request(make_request(MODE_PUSH, 2'd0, 16'h5A5A));
      repeat (5) offer_request(make_request(MODE_POP, 2'd0, 16'h0000));

      // Capacity zero behaves as one
      apply_capacity(5'd0);
      offer_request(make_request(MODE_PUSH, 2'd0, 16'h1234));
      offer_request(make_request(MODE_PUSH, 2'd0, 16'h4321));

      // Capacity above the depth saturates
      apply_capacity(5'd31);
      offer_request(make_request(MODE_PUSH, 2'd0, 16'hBEEF));
      offer_request(make_request(MODE_PUSH, 2'd0, 16'h0001));

      // Capacity lowered under the current fill: entries stay poppable
      apply_capacity(5'd1);
      offer_request(make_request(MODE_PUSH, 2'd0, 16'h7777));
      offer_request(make_request(MODE_PUSH, 2'd2, 16'h8000));
      repeat (4) offer_request(make_request(MODE_POP, 2'd3, 16'hFFFF));
      offer_request(make_request(MODE_PUSH, 2'd0, 16'h00FF));

      // Random phases, each under its own capacity and pacing
      for (int p = 0; p < PHASES; p++) begin
         apply_capacity((p < 8) ? phase_caps[p] : CAP_W'($urandom_range(31)));
         req_gap_pct   = (p == 0) ? 0 : pacing_pct[$urandom_range(2)];
         rsp_stall_pct = (p == 0) ? 0 : pacing_pct[$urandom_range(2)];
         if (p == 3) begin
            // Long response hold-off while requests keep coming back to back
            req_gap_pct  = 0;
            hold_request = 1'b1;
            wait (hold_active);
            repeat (30) offer_request(random_request(70));
         end
         repeat (ITEMS_PER_PHASE) offer_request(random_request(phase_push[p]));
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("Ran %0d requests through %0d capacity settings, one long response hold-off.",
               requests_sent, capacity_settings);
      $display("Responses included %0d pops served and %0d pushes refused on full queues.",
               popped_count, overflow_count);
      if (mismatch_count == 0 && responses_outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/tcspq_pkg.sv
hw/rtl/tcspq_id_store.sv
hw/rtl/three_class_strict_priority_queue.sv
tb/sv/priority_queue_checker.sv
tb/sv/tb_three_class_strict_priority_queue.sv
